@@ rtl/n2a_pkg.sv @@
// Types, codes and the control program shared by the number-to-ASCII formatter.
package n2a_pkg;

  localparam int StepW = 4;
  typedef logic [StepW-1:0] step_t;

  localparam logic [1:0] OP_DEC = 2'd0;
  localparam logic [1:0] OP_HEX = 2'd1;
  localparam logic [1:0] OP_BIN = 2'd2;

  localparam logic [1:0] SZ_8  = 2'd0;
  localparam logic [1:0] SZ_16 = 2'd1;
  localparam logic [1:0] SZ_32 = 2'd2;

  localparam logic [7:0] ASC_ZERO  = 8'h30;
  localparam logic [7:0] ASC_X     = 8'h78;
  localparam logic [7:0] ASC_B     = 8'h62;
  localparam logic [7:0] ASC_MINUS = 8'h2D;
  localparam logic [7:0] ASC_ALPHA = 8'h37;

  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_HEX_0    = 4'd1;
  localparam step_t S_HEX_X    = 4'd2;
  localparam step_t S_HEX_D    = 4'd3;
  localparam step_t S_BIN_0    = 4'd4;
  localparam step_t S_BIN_B    = 4'd5;
  localparam step_t S_BIN_D    = 4'd6;
  localparam step_t S_DEC_Z    = 4'd7;
  localparam step_t S_DEC_S    = 4'd8;
  localparam step_t S_DEC_M    = 4'd9;
  localparam step_t S_DEC_DD   = 4'd10;
  localparam step_t S_DEC_T    = 4'd11;
  localparam step_t S_DEC_LZ   = 4'd12;
  localparam step_t S_DEC_SK   = 4'd13;
  localparam step_t S_DEC_D    = 4'd14;
  localparam step_t S_DEC_ZERO = 4'd15;

  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_DISPATCH, C_ZERO, C_POS, C_CNT_MORE, C_BCD_NZ
  } cond_t;

  typedef enum logic [1:0] {CH_LIT, CH_HEX, CH_BIN, CH_BCD} chsel_t;

  typedef enum logic [1:0] {L_NO, L_YES, L_CNT} lastsel_t;

  typedef enum logic [2:0] {DP_NOP, DP_HEX, DP_BIN, DP_DD, DP_BCD} dpop_t;

  typedef struct packed {
    logic       wait_in;
    logic       emit;
    chsel_t     chsel;
    logic [7:0] lit;
    lastsel_t   lastsel;
    dpop_t      dpop;
    logic       cnt_dec;
    logic       cnt_ten;
    cond_t      cond;
    step_t      target;
    logic       fin;
  } ctrl_t;

  typedef struct packed {
    logic zero;
    logic pos;
    logic cnt_more;
    logic bcd_nz;
    logic out_free;
  } stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = ASC_ZERO + {4'h0, nib};
    end else begin
      c = ASC_ALPHA + {4'h0, nib};
    end
    return c;
  endfunction

  function automatic ctrl_t rom(input step_t s);
    ctrl_t w;
    w = '0;
    case (s)
      S_IDLE: begin
        w.wait_in = 1'b1;
        w.cond    = C_DISPATCH;
      end
      S_HEX_0, S_BIN_0: begin
        w.emit = 1'b1;
        w.lit  = ASC_ZERO;
      end
      S_HEX_X: begin
        w.emit = 1'b1;
        w.lit  = ASC_X;
      end
      S_HEX_D: begin
        w.emit    = 1'b1;
        w.chsel   = CH_HEX;
        w.lastsel = L_CNT;
        w.dpop    = DP_HEX;
        w.cnt_dec = 1'b1;
        w.cond    = C_CNT_MORE;
        w.target  = S_HEX_D;
        w.fin     = 1'b1;
      end
      S_BIN_B: begin
        w.emit = 1'b1;
        w.lit  = ASC_B;
      end
      S_BIN_D: begin
        w.emit    = 1'b1;
        w.chsel   = CH_BIN;
        w.lastsel = L_CNT;
        w.dpop    = DP_BIN;
        w.cnt_dec = 1'b1;
        w.cond    = C_CNT_MORE;
        w.target  = S_BIN_D;
        w.fin     = 1'b1;
      end
      S_DEC_Z: begin
        w.cond   = C_ZERO;
        w.target = S_DEC_ZERO;
      end
      S_DEC_S: begin
        w.cond   = C_POS;
        w.target = S_DEC_DD;
      end
      S_DEC_M: begin
        w.emit = 1'b1;
        w.lit  = ASC_MINUS;
      end
      S_DEC_DD: begin
        w.dpop    = DP_DD;
        w.cnt_dec = 1'b1;
        w.cond    = C_CNT_MORE;
        w.target  = S_DEC_DD;
      end
      S_DEC_T: begin
        w.cnt_ten = 1'b1;
      end
      S_DEC_LZ: begin
        w.cond   = C_BCD_NZ;
        w.target = S_DEC_D;
      end
      S_DEC_SK: begin
        w.dpop    = DP_BCD;
        w.cnt_dec = 1'b1;
        w.cond    = C_ALWAYS;
        w.target  = S_DEC_LZ;
      end
      S_DEC_D: begin
        w.emit    = 1'b1;
        w.chsel   = CH_BCD;
        w.lastsel = L_CNT;
        w.dpop    = DP_BCD;
        w.cnt_dec = 1'b1;
        w.cond    = C_CNT_MORE;
        w.target  = S_DEC_D;
        w.fin     = 1'b1;
      end
      S_DEC_ZERO: begin
        w.emit    = 1'b1;
        w.lit     = ASC_ZERO;
        w.lastsel = L_YES;
        w.fin     = 1'b1;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/number_to_ascii_formatter_top.sv @@
// Top level of the number-to-ASCII formatter: sequencer, datapath and checks.
// Hex and binary: the value is taken, then one character per cycle while the output
// is not stalled; decimal runs the 32-step BCD conversion loop plus the leading-zero
// skip before its digits, and a zero value takes a separate path.
// One value is in work at a time; the next is taken once the last beat is registered.
// Synchronous reset returns the step counter to idle and empties the output register.
module number_to_ascii_formatter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value,
  input  logic [1:0]  opcode,
  input  logic [1:0]  size_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  character,
  output logic        last
);
  import n2a_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  fire;

  n2a_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .stat     (stat),
    .ctrl     (ctrl),
    .fire     (fire)
  );

  n2a_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .fire      (fire),
    .value     (value),
    .opcode    (opcode),
    .size_code (size_code),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .character (character),
    .last      (last)
  );

  assign in_ready = ctrl.wait_in;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (opcode == OP_DEC || opcode == OP_HEX || opcode == OP_BIN)
    |=> !in_ready)
    else $error("formatter took a new value while text was still due");

  a_no_null_char: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> character != 8'h00)
    else $error("formatter presented a null character");

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("formatter not idle after reset");

endmodule

@@ rtl/n2a_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jump logic.
module n2a_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     opcode,
  input  n2a_pkg::stat_t stat,
  output n2a_pkg::ctrl_t ctrl,
  output logic           fire
);
  import n2a_pkg::*;

  step_t step;
  step_t step_next;
  logic  taken;

  assign ctrl = rom(step);
  assign fire = (!ctrl.wait_in || in_valid) && (!ctrl.emit || stat.out_free);

  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:   taken = 1'b1;
      C_DISPATCH: taken = 1'b1;
      C_ZERO:     taken = stat.zero;
      C_POS:      taken = stat.pos;
      C_CNT_MORE: taken = stat.cnt_more;
      C_BCD_NZ:   taken = stat.bcd_nz;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    step_next = step;
    if (fire) begin
      if (ctrl.cond == C_DISPATCH) begin
        case (opcode)
          OP_DEC:  step_next = S_DEC_Z;
          OP_HEX:  step_next = S_HEX_0;
          OP_BIN:  step_next = S_BIN_0;
          default: step_next = S_IDLE;
        endcase
      end else if (taken) begin
        step_next = ctrl.target;
      end else if (ctrl.fin) begin
        step_next = S_IDLE;
      end else begin
        step_next = step + step_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

@@ rtl/n2a_dp.sv @@
// Datapath: value shifter, BCD converter, step count and output register.
module n2a_dp (
  input  logic           clk,
  input  logic           rst,
  input  n2a_pkg::ctrl_t ctrl,
  input  logic           fire,
  input  logic [63:0]    value,
  input  logic [1:0]     opcode,
  input  logic [1:0]     size_code,
  input  logic           out_ready,
  output n2a_pkg::stat_t stat,
  output logic           out_valid,
  output logic [7:0]     character,
  output logic           last
);
  import n2a_pkg::*;

  logic [63:0] sh;
  logic [39:0] bcd;
  logic [5:0]  cnt;
  logic        neg;
  logic        zero_f;

  logic        load;
  logic        emit_now;
  logic [31:0] raw;
  logic [31:0] mag;
  logic [63:0] sh_load;
  logic [5:0]  cnt_load;
  logic [39:0] bcd_adj;
  logic [7:0]  char_next;
  logic        last_next;

  assign load     = fire && ctrl.wait_in;
  assign emit_now = fire && ctrl.emit;
  assign raw      = value[31:0];
  assign mag      = raw[31] ? (32'd0 - raw) : raw;

  always_comb begin
    case (opcode)
      OP_HEX: begin
        case (size_code)
          SZ_8:    begin sh_load = value << 56; cnt_load = 6'd2; end
          SZ_16:   begin sh_load = value << 48; cnt_load = 6'd4; end
          SZ_32:   begin sh_load = value << 32; cnt_load = 6'd8; end
          default: begin sh_load = value;       cnt_load = 6'd16; end
        endcase
      end
      OP_BIN: begin
        case (size_code)
          SZ_8:    begin sh_load = value << 56; cnt_load = 6'd8; end
          SZ_16:   begin sh_load = value << 48; cnt_load = 6'd16; end
          default: begin sh_load = value << 32; cnt_load = 6'd32; end
        endcase
      end
      default: begin
        sh_load  = {32'd0, mag};
        cnt_load = 6'd32;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 10; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_comb begin
    case (ctrl.chsel)
      CH_HEX:  char_next = hex_char(sh[63:60]);
      CH_BIN:  char_next = ASC_ZERO + {7'd0, sh[63]};
      CH_BCD:  char_next = ASC_ZERO + {4'd0, bcd[39:36]};
      default: char_next = ctrl.lit;
    endcase
    case (ctrl.lastsel)
      L_YES:   last_next = 1'b1;
      L_CNT:   last_next = (cnt == 6'd1);
      default: last_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh     <= sh_load;
      bcd    <= '0;
      neg    <= raw[31];
      zero_f <= (raw == 32'd0);
    end else if (fire) begin
      case (ctrl.dpop)
        DP_HEX: sh <= {sh[59:0], 4'h0};
        DP_BIN: sh <= {sh[62:0], 1'b0};
        DP_DD: begin
          bcd <= {bcd_adj[38:0], sh[31]};
          sh  <= {sh[62:0], 1'b0};
        end
        DP_BCD:  bcd <= {bcd[35:0], 4'h0};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cnt <= cnt_load;
    end else if (fire && ctrl.cnt_ten) begin
      cnt <= 6'd10;
    end else if (fire && ctrl.cnt_dec) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_now) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_now) begin
      character <= char_next;
      last      <= last_next;
    end
  end

  assign stat.zero     = zero_f;
  assign stat.pos      = !neg;
  assign stat.cnt_more = (cnt != 6'd1);
  assign stat.bcd_nz   = (bcd[39:36] != 4'h0);
  assign stat.out_free = !out_valid || out_ready;

endmodule
